/* design/pat_pkg.sv */
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants, codes and controller/datapath interface types for the
// priority alert table.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 4;

	localparam logic [2:0] MODE_POST    = 3'd0;
	localparam logic [2:0] MODE_CLEAR   = 3'd1;
	localparam logic [2:0] MODE_DISMISS = 3'd2;
	localparam logic [2:0] MODE_FOCUS   = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;
	localparam logic [2:0] MODE_RESET   = 3'd5;

	localparam logic [0:0] REG_INFO_TTL   = 1'd0;
	localparam logic [0:0] REG_INFO_LEVEL = 1'd1;

	localparam logic [31:0] TTL_RESET = 32'd5000;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_en;
		logic mark;
		logic apply;
		logic compact;
		logic settle;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic rm_any;
	} status_t;

endpackage

/* design/pat_ctrl.sv */
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer for one transaction: capture, table scan, update, compaction,
// top scan and result hand-off.
// ----------------------------------------------------------------------------
module pat_ctrl import pat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN1   = 3'd1;
	localparam logic [2:0] ST_APPLY   = 3'd2;
	localparam logic [2:0] ST_COMPACT = 3'd3;
	localparam logic [2:0] ST_SCAN2   = 3'd4;
	localparam logic [2:0] ST_EMIT    = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN1;
				end
			end
			ST_SCAN1: begin
				if (status.scan_done) begin
					state_d = ST_APPLY;
				end else begin
					cmd.scan_en = 1'b1;
					cmd.mark    = 1'b1;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_COMPACT;
			end
			ST_COMPACT: begin
				if (status.rm_any) begin
					cmd.compact = 1'b1;
				end else begin
					cmd.settle   = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN2;
				end
			end
			ST_SCAN2: begin
				if (status.scan_done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.scan_en = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/pat_datapath.sv */
// ----------------------------------------------------------------------------
// pat_datapath
// Alert entries, counters, configuration registers, scan trackers and the
// result register.
// ----------------------------------------------------------------------------
module pat_datapath import pat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  in_mode,
	input  logic [42:0] in_data,
	input  cmd_t        cmd,
	output status_t     status,
	output logic [55:0] out_data
);

	logic [31:0] ttl_q;
	logic [1:0]  info_lvl_q;
	logic [31:0] time_q;
	logic [31:0] serial_q;
	logic        focus_q;
	logic [CNT_W-1:0] count_q;

	logic [3:0]  e_src [CAPACITY];
	logic [1:0]  e_lvl [CAPACITY];
	logic [3:0]  e_act [CAPACITY];
	logic [31:0] e_tag [CAPACITY];
	logic [31:0] e_ser [CAPACITY];
	logic [31:0] e_exp [CAPACITY];
	logic [CAPACITY-1:0] rm_q;

	logic [2:0]  mode_q;
	logic [3:0]  src_q;
	logic [1:0]  lvl_q;
	logic [3:0]  act_q;
	logic [31:0] tag_q;
	logic        fon_q;
	logic        accepted_q;
	logic        changed_q;

	logic [CNT_W-1:0] idx_q;
	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             ident_q;
	logic             top_found_q;
	logic [IDX_W-1:0] top_idx_q;
	logic [3:0]       top_src_q;
	logic [1:0]       top_lvl_q;
	logic [3:0]       top_act_q;
	logic [31:0]      top_tag_q;
	logic [31:0]      top_ser_q;
	logic             weak_found_q;
	logic [IDX_W-1:0] weak_idx_q;
	logic [1:0]       weak_lvl_q;
	logic [31:0]      weak_ser_q;

	logic [IDX_W-1:0] ci;
	logic [3:0]  c_src;
	logic [1:0]  c_lvl;
	logic [31:0] c_ser;
	logic [31:0] c_exp;
	logic        c_srcm;
	logic        c_expired;
	logic        top_upd;
	logic        weak_upd;
	logic [31:0] exp_sum;
	logic [31:0] new_exp;
	logic [31:0] time_diff;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             refresh;
	logic             grow;
	logic [IDX_W-1:0] rm_low;
	logic             new_focus;

	assign ci    = idx_q[IDX_W-1:0];
	assign c_src = e_src[ci];
	assign c_lvl = e_lvl[ci];
	assign c_ser = e_ser[ci];
	assign c_exp = e_exp[ci];
	assign c_srcm = (c_src == src_q);
	assign time_diff = time_q - c_exp;
	assign c_expired = (c_exp != 32'd0) && !time_diff[31];
	assign top_upd  = !top_found_q || (c_lvl > top_lvl_q) ||
		((c_lvl == top_lvl_q) && (c_ser > top_ser_q));
	assign weak_upd = !weak_found_q || (c_lvl < weak_lvl_q) ||
		((c_lvl == weak_lvl_q) && (c_ser < weak_ser_q));

	assign exp_sum = time_q + ttl_q;
	assign new_exp = (lvl_q != info_lvl_q) ? 32'd0 :
		((exp_sum == 32'd0) ? 32'd1 : exp_sum);

	assign status.scan_done = (idx_q >= count_q);
	assign status.rm_any    = |rm_q;

	assign new_focus = fon_q && (count_q != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = '0;
		refresh = 1'b0;
		grow    = 1'b0;
		if (mode_q == MODE_POST) begin
			if (match_q) begin
				if (ident_q) begin
					refresh = 1'b1;
				end else begin
					wr_en = 1'b1;
				end
				wr_idx = match_idx_q;
			end else if (count_q < CNT_W'(CAPACITY)) begin
				wr_en  = 1'b1;
				grow   = 1'b1;
				wr_idx = count_q[IDX_W-1:0];
			end else if (weak_lvl_q <= lvl_q) begin
				wr_en  = 1'b1;
				wr_idx = weak_idx_q;
			end
		end
	end

	always_comb begin
		rm_low = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (rm_q[k]) begin
				rm_low = IDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q      <= TTL_RESET;
			info_lvl_q <= 2'd0;
			time_q     <= '0;
			serial_q   <= '0;
			focus_q    <= 1'b0;
			count_q    <= '0;
			rm_q       <= '0;
			idx_q      <= '0;
			mode_q     <= MODE_POST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_INFO_TTL:   ttl_q      <= cfg_data;
					REG_INFO_LEVEL: info_lvl_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				mode_q <= in_mode;
				if (in_mode == MODE_TICK) begin
					time_q <= time_q + 32'd1;
				end
			end
			if (cmd.scan_clr) begin
				idx_q <= '0;
			end else if (cmd.scan_en) begin
				idx_q <= idx_q + CNT_W'(1);
				if (cmd.mark && (((mode_q == MODE_CLEAR) && c_srcm) ||
						((mode_q == MODE_TICK) && c_expired))) begin
					rm_q[ci] <= 1'b1;
				end
			end
			if (cmd.apply) begin
				unique case (mode_q)
					MODE_POST: begin
						if (wr_en) begin
							serial_q <= serial_q + 32'd1;
						end
						if (grow) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					MODE_DISMISS: begin
						if (top_found_q) begin
							rm_q[top_idx_q] <= 1'b1;
							focus_q         <= 1'b0;
						end
					end
					MODE_FOCUS: focus_q <= new_focus;
					MODE_RESET: begin
						count_q <= '0;
						focus_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.compact) begin
				for (int k = 0; k < CAPACITY - 1; k++) begin
					if (IDX_W'(k) >= rm_low) begin
						rm_q[k] <= rm_q[k+1];
					end
				end
				rm_q[CAPACITY-1] <= 1'b0;
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.settle && changed_q && (count_q == '0)) begin
				focus_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q      <= in_data[3:0];
			lvl_q      <= in_data[5:4];
			act_q      <= in_data[9:6];
			tag_q      <= in_data[41:10];
			fon_q      <= in_data[42];
			accepted_q <= 1'b1;
			changed_q  <= 1'b0;
		end
		if (cmd.scan_clr) begin
			match_q      <= 1'b0;
			ident_q      <= 1'b0;
			top_found_q  <= 1'b0;
			weak_found_q <= 1'b0;
		end else if (cmd.scan_en) begin
			if (c_srcm) begin
				match_q     <= 1'b1;
				match_idx_q <= ci;
				ident_q     <= (c_lvl == lvl_q) && (e_act[ci] == act_q) &&
					(e_tag[ci] == tag_q);
			end
			if (top_upd) begin
				top_found_q <= 1'b1;
				top_idx_q   <= ci;
				top_src_q   <= c_src;
				top_lvl_q   <= c_lvl;
				top_act_q   <= e_act[ci];
				top_tag_q   <= e_tag[ci];
				top_ser_q   <= c_ser;
			end
			if (weak_upd) begin
				weak_found_q <= 1'b1;
				weak_idx_q   <= ci;
				weak_lvl_q   <= c_lvl;
				weak_ser_q   <= c_ser;
			end
		end
		if (cmd.apply) begin
			if (mode_q == MODE_POST) begin
				if (!match_q && !grow && !wr_en) begin
					accepted_q <= 1'b0;
				end
				if (wr_en) begin
					changed_q     <= 1'b1;
					e_src[wr_idx] <= src_q;
					e_lvl[wr_idx] <= lvl_q;
					e_act[wr_idx] <= act_q;
					e_tag[wr_idx] <= tag_q;
					e_ser[wr_idx] <= serial_q + 32'd1;
					e_exp[wr_idx] <= new_exp;
				end else if (refresh) begin
					e_exp[wr_idx] <= new_exp;
				end
			end else if (mode_q == MODE_FOCUS && new_focus != focus_q) begin
				changed_q <= 1'b1;
			end
		end
		if (cmd.compact) begin
			changed_q <= 1'b1;
			for (int k = 0; k < CAPACITY - 1; k++) begin
				if (IDX_W'(k) >= rm_low) begin
					e_src[k] <= e_src[k+1];
					e_lvl[k] <= e_lvl[k+1];
					e_act[k] <= e_act[k+1];
					e_tag[k] <= e_tag[k+1];
					e_ser[k] <= e_ser[k+1];
					e_exp[k] <= e_exp[k+1];
				end
			end
		end
		if (cmd.out_load) begin
			out_data[0]     <= accepted_q;
			out_data[1]     <= changed_q;
			out_data[2]     <= top_found_q;
			out_data[6:3]   <= top_found_q ? top_src_q : 4'd0;
			out_data[8:7]   <= top_found_q ? top_lvl_q : 2'd0;
			out_data[12:9]  <= top_found_q ? top_act_q : 4'd0;
			out_data[44:13] <= top_found_q ? top_tag_q : 32'd0;
			out_data[48:45] <= OUT_CNT_W'(count_q);
			out_data[49]    <= focus_q;
			out_data[55:50] <= 6'd0;
		end
	end

endmodule

/* design/priority_alert_table.sv */
// ----------------------------------------------------------------------------
// priority_alert_table
// Bounded table of alerts, one per source, with post, clear, dismiss, focus,
// tick and table reset commands.
// ----------------------------------------------------------------------------
// Usage: one command enters on the s_ channel (mode in s_tuser, alert fields
// in s_tdata); exactly one result leaves on the m_ channel with the top
// alert, the alert count and the focus flag. Configuration (lifetime and
// expiring level) is written through cfg_we/cfg_addr/cfg_data while idle.
// Throughput: one transaction at a time. Time from acceptance to m_tvalid
// grows with the alerts stored before the command, those stored after it and
// the alerts removed: each stored entry is visited once in the table scan and
// again in the top scan, each removal takes its own compaction step, and
// capture, update, the scan ends and hand-off add the rest. The next command
// is accepted in the cycle after the result is loaded.
// Reset: table empty, time and serial counters zero, focus off, lifetime
// 5000, expiring level 0. A result register holds the finished result; when
// the receiver stalls the next command is still accepted and processed,
// and it waits at hand-off until the held result is taken.
// ----------------------------------------------------------------------------
module priority_alert_table import pat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// source[3:0], level[5:4], action[9:6], content_tag[41:10], focus_on[42]
	input  logic [47:0] s_tdata,
	// mode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted[0], view_changed[1], has_top[2], top_source[6:3],
	// top_level[8:7], top_action[12:9], top_tag[44:13], alert_count[48:45],
	// focus_flag[49]
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	pat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pat_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_mode  (s_tuser),
		.in_data  (s_tdata[42:0]),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_tdata)
	);

endmodule

/* tb/tb_priority_alert_table.sv */
// ----------------------------------------------------------------------------
// tb_priority_alert_table
// Drives post, clear, dismiss, focus, tick and table reset commands into the
// alert table with random gaps and output stalls, predicts every result with
// a behavioral table model and compares each whole result with its prediction.
// ----------------------------------------------------------------------------
module tb_priority_alert_table;
	import pat_pkg::*;

	typedef struct packed {
		logic        focus;
		logic [3:0]  cnt;
		logic [31:0] tag;
		logic [3:0]  act;
		logic [1:0]  lvl;
		logic [3:0]  src;
		logic        has_top;
		logic        changed;
		logic        accepted;
	} alert_view_t;

	class alert_scoreboard;
		logic [31:0] ttl;
		logic [1:0]  exp_level;
		logic [31:0] now;
		logic [31:0] serial;
		int          n;
		logic [3:0]  e_src [CAPACITY];
		logic [1:0]  e_lvl [CAPACITY];
		logic [3:0]  e_act [CAPACITY];
		logic [31:0] e_tag [CAPACITY];
		logic [31:0] e_ser [CAPACITY];
		logic [31:0] e_exp [CAPACITY];
		logic        focus;
		alert_view_t pending[$];
		int          errors;
		int          checked;

		function new();
			ttl = TTL_RESET;
			exp_level = 0;
			now = 0;
			serial = 0;
			n = 0;
			focus = 0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] expiry_for(logic [1:0] l);
			logic [31:0] e;
			if (l != exp_level)
				return 0;
			e = now + ttl;
			return (e == 0) ? 32'd1 : e;
		endfunction

		function int top_slot();
			int b;
			b = -1;
			for (int i = 0; i < n; i++)
				if (b < 0 || e_lvl[i] > e_lvl[b] ||
						(e_lvl[i] == e_lvl[b] && e_ser[i] > e_ser[b]))
					b = i;
			return b;
		endfunction

		function void remove_slot(int idx);
			for (int k = idx + 1; k < n; k++) begin
				e_src[k-1] = e_src[k];
				e_lvl[k-1] = e_lvl[k];
				e_act[k-1] = e_act[k];
				e_tag[k-1] = e_tag[k];
				e_ser[k-1] = e_ser[k];
				e_exp[k-1] = e_exp[k];
			end
			n--;
		endfunction

		function void note_command(logic [2:0] mode, logic [47:0] d);
			logic [3:0]  src;
			logic [1:0]  lvl;
			logic [3:0]  act;
			logic [31:0] tag;
			logic        fon;
			logic [31:0] dif;
			alert_view_t r;
			int          slot, weakest, t;
			bit          wr;
			src = d[3:0];
			lvl = d[5:4];
			act = d[9:6];
			tag = d[41:10];
			fon = d[42];
			r = '0;
			r.accepted = 1;
			case (mode)
				MODE_POST: begin
					slot = -1;
					wr = 1;
					for (int i = 0; i < n; i++)
						if (e_src[i] == src)
							slot = i;
					if (slot >= 0) begin
						if (e_lvl[slot] == lvl && e_act[slot] == act &&
								e_tag[slot] == tag) begin
							e_exp[slot] = expiry_for(lvl);
							wr = 0;
						end
					end else if (n < CAPACITY) begin
						slot = n;
						n++;
					end else begin
						weakest = 0;
						for (int i = 1; i < n; i++)
							if (e_lvl[i] < e_lvl[weakest] ||
									(e_lvl[i] == e_lvl[weakest] &&
									e_ser[i] < e_ser[weakest]))
								weakest = i;
						if (e_lvl[weakest] > lvl) begin
							r.accepted = 0;
							wr = 0;
						end else begin
							slot = weakest;
						end
					end
					if (wr && slot >= 0) begin
						serial++;
						e_src[slot] = src;
						e_lvl[slot] = lvl;
						e_act[slot] = act;
						e_tag[slot] = tag;
						e_ser[slot] = serial;
						e_exp[slot] = expiry_for(lvl);
						r.changed = 1;
					end
				end
				MODE_CLEAR: begin
					for (int i = n - 1; i >= 0; i--)
						if (e_src[i] == src) begin
							remove_slot(i);
							r.changed = 1;
						end
				end
				MODE_DISMISS: begin
					t = top_slot();
					if (t >= 0) begin
						remove_slot(t);
						focus = 0;
						r.changed = 1;
					end
				end
				MODE_FOCUS: begin
					if ((fon && n > 0) != focus) begin
						focus = fon && n > 0;
						r.changed = 1;
					end
				end
				MODE_TICK: begin
					now++;
					for (int i = n - 1; i >= 0; i--) begin
						dif = now - e_exp[i];
						if (e_exp[i] != 0 && !dif[31]) begin
							remove_slot(i);
							r.changed = 1;
						end
					end
				end
				MODE_RESET: begin
					n = 0;
					focus = 0;
				end
				default: ;
			endcase
			if (r.changed && n == 0)
				focus = 0;
			t = top_slot();
			if (t >= 0) begin
				r.has_top = 1;
				r.src = e_src[t];
				r.lvl = e_lvl[t];
				r.act = e_act[t];
				r.tag = e_tag[t];
			end
			r.cnt = n[3:0];
			r.focus = focus;
			pending.push_back(r);
		endfunction

		function void check_result(logic [55:0] d);
			alert_view_t got, exp_r;
			got = d[49:0];
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r || d[55:50] !== 6'd0) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch result %0d: expected acc=%0d chg=%0d top=%0d %s",
						checked, exp_r.accepted, exp_r.changed, exp_r.has_top, "");
					$display("  src=%0d lvl=%0d act=%0d tag=%h cnt=%0d foc=%0d",
						exp_r.src, exp_r.lvl, exp_r.act, exp_r.tag, exp_r.cnt,
						exp_r.focus);
					$display("  got acc=%0d chg=%0d top=%0d src=%0d lvl=%0d act=%0d",
						got.accepted, got.changed, got.has_top, got.src, got.lvl,
						got.act);
					$display("  tag=%h cnt=%0d foc=%0d pad=%h",
						got.tag, got.cnt, got.focus, d[55:50]);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        cfg_we;
	logic [0:0]  cfg_addr;
	logic [31:0] cfg_data;

	alert_scoreboard board;
	int          cycles;
	bit          stall_on;
	int          sent;
	int          mode_hits[8];

	priority_alert_table u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout");
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls, with stall-free stretches
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 0;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				stall_left <= gap_len();
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic send_cmd(logic [2:0] mode, logic [3:0] src, logic [1:0] lvl,
			logic [3:0] act, logic [31:0] tag, logic fon);
		logic [47:0] d;
		int g;
		d = '0;
		d[3:0] = src;
		d[5:4] = lvl;
		d[9:6] = act;
		d[41:10] = tag;
		d[42] = fon;
		s_tvalid <= 1;
		s_tuser <= mode;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_command(mode, d);
		mode_hits[mode]++;
		sent++;
		g = stall_on ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		drain();
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_INFO_TTL)
			board.ttl = val;
		else
			board.exp_level = val[1:0];
	endtask

	task automatic random_cmd(bit small_tags);
		int p;
		logic [2:0] m;
		logic [3:0] src;
		logic [1:0] lvl;
		logic [3:0] act;
		logic [31:0] tag;
		logic fon;
		p = $urandom_range(0, 99);
		if (p < 45)      m = MODE_POST;
		else if (p < 55) m = MODE_CLEAR;
		else if (p < 63) m = MODE_DISMISS;
		else if (p < 70) m = MODE_FOCUS;
		else if (p < 94) m = MODE_TICK;
		else if (p < 96) m = MODE_RESET;
		else             m = 3'($urandom_range(6, 7));
		src = small_tags ? 4'($urandom_range(0, 11)) : 4'($urandom_range(0, 15));
		lvl = 2'($urandom_range(0, 3));
		act = small_tags ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
		tag = small_tags ? $urandom_range(0, 3) : $urandom;
		fon = 1'($urandom_range(0, 1));
		send_cmd(m, src, lvl, act, tag, fon);
	endtask

	initial begin
		board = new();
		cycles = 0;
		sent = 0;
		stall_on = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = MODE_POST;
		cfg_we = 0;
		cfg_addr = REG_INFO_TTL;
		cfg_data = '0;
		foreach (mode_hits[i]) mode_hits[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty-table commands, fill, same-source overwrite, refusal, refresh, expiry
		send_cmd(MODE_DISMISS, 0, 0, 0, 0, 0);
		send_cmd(MODE_FOCUS, 0, 0, 0, 0, 1);
		send_cmd(MODE_CLEAR, 3, 0, 0, 0, 0);
		send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			send_cmd(MODE_POST, 4'(i * 2 + 1), 3, 15, 32'(32'hFFFF_FFFF - i), 1);
		send_cmd(MODE_POST, 0, 0, 0, 0, 0);
		send_cmd(MODE_POST, 15, 3, 4, 32'h5a5a5a5a, 0);
		send_cmd(MODE_POST, 15, 3, 4, 32'h5a5a5a5a, 0);
		send_cmd(MODE_FOCUS, 0, 0, 0, 0, 1);
		send_cmd(MODE_DISMISS, 0, 0, 0, 0, 0);
		send_cmd(MODE_CLEAR, 15, 0, 0, 0, 0);
		send_cmd(3'd6, 0, 0, 0, 0, 0);
		send_cmd(3'd7, 15, 3, 15, 32'hFFFF_FFFF, 1);
		send_cmd(MODE_RESET, 0, 0, 0, 0, 0);
		write_reg(REG_INFO_TTL, 1);
		write_reg(REG_INFO_LEVEL, 3);
		send_cmd(MODE_POST, 2, 3, 1, 32'h1, 0);
		send_cmd(MODE_POST, 4, 0, 1, 32'h2, 0);
		send_cmd(MODE_TICK, 0, 0, 0, 0, 0);
		// expiry sum wraps around past zero and is stored as one
		write_reg(REG_INFO_TTL, 32'hFFFF_FFFF);
		send_cmd(MODE_POST, 5, 3, 2, 32'h3, 0);
		send_cmd(MODE_TICK, 0, 0, 0, 0, 0);

		stall_on = 1;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_INFO_TTL, 3);
					write_reg(REG_INFO_LEVEL, 0);
				end
				1: begin
					write_reg(REG_INFO_TTL, 32'hFFFF_FFFF);
					write_reg(REG_INFO_LEVEL, 2);
				end
				2: write_reg(REG_INFO_TTL, 32'h8000_0000);
				3: begin
					write_reg(REG_INFO_TTL, $urandom_range(1, 20));
					write_reg(REG_INFO_LEVEL, 1);
				end
				4: write_reg(REG_INFO_TTL, 32'h7FFF_FFFF);
				default: begin
					write_reg(REG_INFO_TTL, 1);
					write_reg(REG_INFO_LEVEL, 3);
				end
			endcase
			stall_on = (ph != 2);
			for (int k = 0; k < 300; k++)
				random_cmd(k % 3 != 0);
		end
		drain();
		$display("covered %0d commands: post %0d clear %0d dismiss %0d focus %0d",
			sent, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		$display("tick %0d reset %0d; %0d results checked, %0d mismatches",
			mode_hits[4], mode_hits[5], board.checked, board.errors);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

/* files.f */
design/pat_pkg.sv
design/pat_ctrl.sv
design/pat_datapath.sv
design/priority_alert_table.sv
tb/tb_priority_alert_table.sv
